// ===== hw/rtl/cham_pkg.sv =====
`timescale 1ns / 1ps

package cham_pkg;

  // Pipeline depth: one stage per round of the longest variant
  localparam int unsigned NumStages = 120;
  localparam int unsigned StageW = 7;

  localparam logic [6:0] Rounds64 = 7'd88;
  localparam logic [6:0] Rounds128 = 7'd112;
  localparam logic [6:0] Rounds256 = 7'd120;

  localparam logic [3:0] KsRotA = 4'd1;
  localparam logic [3:0] KsRotB = 4'd8;
  localparam logic [3:0] KsRotC = 4'd11;

  // Variant codes
  localparam logic [1:0] VAR_64_128 = 2'd0;
  localparam logic [1:0] VAR_128_128 = 2'd1;

  // Configuration register indexes
  localparam logic [2:0] REG_VARIANT = 3'd0;
  localparam logic [2:0] REG_KEY0 = 3'd1;
  localparam logic [2:0] REG_KEY1 = 3'd2;
  localparam logic [2:0] REG_KEY2 = 3'd3;
  localparam logic [2:0] REG_KEY3 = 3'd4;

  localparam logic CMD_DECRYPT = 1'b1;

  typedef logic [15:0][31:0] cham_rk_t;

  // One block in flight
  typedef struct packed {
    logic [3:0][31:0] x;
    logic             dec;
    logic [1:0]       variant;
  } cham_item_t;

  typedef struct packed {
    logic       valid;
    cham_item_t item;
  } cham_pipe_t;

  // Rotate left within a 16-bit or 32-bit word
  function automatic logic [31:0] cham_rotl(input logic [31:0] v, input logic [4:0] amt,
                                            input logic narrow);
    logic [31:0] d16;
    logic [63:0] d32;
    begin
      d16 = {v[15:0], v[15:0]} << amt;
      d32 = {v, v} << amt;
      cham_rotl = narrow ? {16'h0, d16[31:16]} : d32[63:32];
    end
  endfunction

  function automatic logic [31:0] cham_mask(input logic [31:0] v, input logic narrow);
    cham_mask = narrow ? {16'h0, v[15:0]} : v;
  endfunction

endpackage

// ===== hw/rtl/cham_key_sched.sv =====
`timescale 1ns / 1ps

module cham_key_sched (
  input  logic [1:0]            variant,
  input  logic [3:0][63:0]      key,
  output cham_pkg::cham_rk_t    rk
);
  import cham_pkg::*;

  logic       narrow;
  logic [3:0] nk;
  logic [7:0][31:0] mk;

  assign narrow = (variant == VAR_64_128);
  assign nk = (variant == VAR_128_128) ? 4'd4 : 4'd8;

  // Master key words, little-endian
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (narrow) begin
        mk[i] = {16'h0, key[i >> 2][16 * (i % 4) +: 16]};
      end else begin
        mk[i] = key[i >> 1][32 * (i % 2) +: 32];
      end
    end
  end

  // Round keys: k^rol1^rol8 and k^rol1^rol11 at the swapped upper slot
  always_comb begin
    logic [31:0] t;
    logic [3:0]  hi;
    rk = '0;
    for (int i = 0; i < 8; i++) begin
      t = mk[i] ^ cham_rotl(mk[i], {1'b0, KsRotA}, narrow);
      hi = (4'(i) + nk) ^ 4'd1;
      if (4'(i) < nk) begin
        rk[i] = t ^ cham_rotl(mk[i], {1'b0, KsRotB}, narrow);
        rk[hi] = t ^ cham_rotl(mk[i], {1'b0, KsRotC}, narrow);
      end
    end
  end

endmodule

// ===== hw/rtl/cham_round.sv =====
`timescale 1ns / 1ps

module cham_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [6:0]           stage_idx,
  input  cham_pkg::cham_rk_t   rk,
  input  cham_pkg::cham_pipe_t pin,
  output cham_pkg::cham_pipe_t pout
);
  import cham_pkg::*;

  logic        narrow;
  logic [6:0]  nrounds;
  logic        active;
  logic [6:0]  r;
  logic [1:0]  j;
  logic [1:0]  n;
  logic [3:0]  kidx;
  logic [4:0]  ri;
  logic [4:0]  ro;
  logic [31:0] b;
  logic [31:0] a;
  logic [31:0] newx;
  cham_item_t  item_nxt;
  logic        valid_r;
  cham_item_t  item_r;

  assign narrow = (pin.item.variant == VAR_64_128);

  always_comb begin
    case (pin.item.variant)
      VAR_64_128:  nrounds = Rounds64;
      VAR_128_128: nrounds = Rounds128;
      default:     nrounds = Rounds256;
    endcase
  end

  // Round number this stage applies; decryption walks the rounds backward
  assign active = (stage_idx < nrounds);
  assign r = (pin.item.dec == CMD_DECRYPT) ? (nrounds - 7'd1 - stage_idx) : stage_idx;
  assign j = r[1:0];
  assign n = r[1:0] + 2'd1;
  assign kidx = (pin.item.variant == VAR_128_128) ? {1'b0, r[2:0]} : r[3:0];
  assign ri = r[0] ? 5'd8 : 5'd1;
  assign ro = r[0] ? 5'd1 : 5'd8;

  // Add-rotate-xor and its inverse
  always_comb begin
    b = cham_rotl(pin.item.x[n], ri, narrow) ^ rk[kidx];
    if (pin.item.dec == CMD_DECRYPT) begin
      a = cham_rotl(pin.item.x[j], (narrow ? 5'd16 : 5'd0) - ro, narrow) - b;
      newx = cham_mask(a ^ {25'h0, r}, narrow);
    end else begin
      a = pin.item.x[j] ^ {25'h0, r};
      newx = cham_rotl(cham_mask(a + b, narrow), ro, narrow);
    end
    item_nxt = pin.item;
    if (active) begin
      item_nxt.x[j] = newx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= pin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign pout.valid = valid_r;
  assign pout.item = item_r;

endmodule

// ===== hw/rtl/cham_block_cipher_core.sv =====
`timescale 1ns / 1ps

// CHAM block cipher (64/128, 128/128, 128/256) as a fully unrolled pipeline of
// 120 round stages, one round per stage. A request is accepted every cycle while
// in_stall is low and passes through every round stage register to the output, for
// every variant (shorter variants pass through the unused tail stages). The whole
// pipeline freezes only while a finished result sits at the output and out_stall
// is high. Round keys are derived from the key registers; write configuration only while idle.
module cham_block_cipher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [63:0] in_block_lo,
  input  logic [63:0] in_block_hi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_lo,
  output logic [63:0] out_result_hi
);
  import cham_pkg::*;

  logic [1:0]       variant_r;
  logic [3:0][63:0] key_r;
  cham_rk_t         rk;
  logic             adv;
  cham_pipe_t       head;
  cham_pipe_t       pipe [NumStages+1];
  cham_item_t       last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= '0;
      key_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VARIANT: variant_r <= cfg_wdata[1:0];
        REG_KEY0:    key_r[0] <= cfg_wdata;
        REG_KEY1:    key_r[1] <= cfg_wdata;
        REG_KEY2:    key_r[2] <= cfg_wdata;
        REG_KEY3:    key_r[3] <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  cham_key_sched u_ks (
    .variant (variant_r),
    .key     (key_r),
    .rk      (rk)
  );

  // Global advance: hold only when the result register is stalled
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Block words, little-endian
  always_comb begin
    head.valid = in_valid;
    head.item.dec = in_command;
    head.item.variant = variant_r;
    if (variant_r == VAR_64_128) begin
      for (int i = 0; i < 4; i++) begin
        head.item.x[i] = {16'h0, in_block_lo[16 * i +: 16]};
      end
    end else begin
      head.item.x[0] = in_block_lo[31:0];
      head.item.x[1] = in_block_lo[63:32];
      head.item.x[2] = in_block_hi[31:0];
      head.item.x[3] = in_block_hi[63:32];
    end
  end

  assign pipe[0] = head;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    cham_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .stage_idx (StageW'(g)),
      .rk        (rk),
      .pin       (pipe[g]),
      .pout      (pipe[g+1])
    );
  end

  // Result packing
  assign last = pipe[NumStages].item;
  assign out_valid = pipe[NumStages].valid;
  always_comb begin
    if (last.variant == VAR_64_128) begin
      out_result_lo = {last.x[3][15:0], last.x[2][15:0], last.x[1][15:0], last.x[0][15:0]};
      out_result_hi = '0;
    end else begin
      out_result_lo = {last.x[1], last.x[0]};
      out_result_hi = {last.x[3], last.x[2]};
    end
  end

  // A stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_lo)))
    else $error("result changed under stall");

  // A request entering moves into the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> pipe[1].valid)
    else $error("accepted request lost");

  // Narrow variant returns a zero upper half
  a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && last.variant == VAR_64_128) |-> (out_result_hi == 64'h0))
    else $error("nonzero high half in 64-bit variant");

endmodule
